// ----- sv/nlf_pkg.sv -----
// ----------------------------------------------------------------------------
// nlf_pkg
// types and constants shared by the natural log blocks
// ----------------------------------------------------------------------------
package nlf_pkg;

  localparam int unsigned DivStages = 15;   // two quotient bits per stage
  localparam int unsigned OutDepth  = 32;   // result queue entries
  localparam int unsigned MidDepth  = 4;    // front to back queue entries

  localparam logic [31:0] ExpMask  = 32'h7F80_0000;
  localparam logic [30:0] C3Q30    = 31'd357913952;
  localparam logic [30:0] C5Q30    = 31'd214748336;
  localparam logic [30:0] C7Q30    = 31'd153392320;
  localparam logic [30:0] C9Q30    = 31'd119493752;
  localparam logic [30:0] OneQ30   = 31'd1073741824;
  localparam logic [30:0] Ln2Q30   = 31'd744261120;
  localparam logic [8:0]  ExpBias  = 9'd127;

  // classified item
  typedef struct packed {
    logic              inv;
    logic signed [7:0] expo;
    logic [22:0]       frac;
  } item_t;

  // divider result
  typedef struct packed {
    logic              inv;
    logic signed [7:0] expo;
    logic [28:0]       z;
  } zitem_t;

  // finished result
  typedef struct packed {
    logic        inv;
    logic [31:0] ln;
  } res_t;

endpackage

// ----- sv/natural_log_float_to_fixed.sv -----
// path from push to empty low when the queues are empty:
// (front queue written at the push edge, 15 divider stages, 7 series/rounding stages, 1 result queue)
// throughput: one item per cycle; the 15-stage divider is fully pipelined
// rate holds while out_pop keeps up; one result slot is reserved per item, 32 in all
// reset: synchronous active-low rst_n empties both queues and the pipeline
// ----------------------------------------------------------------------------
// natural_log_float_to_fixed
// natural log of a single-precision pattern as two's complement fixed point
// ----------------------------------------------------------------------------
module natural_log_float_to_fixed #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [31:0]        in_x_bits,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_ln_value,
  output logic               out_invalid
);
  import nlf_pkg::*;

  localparam int unsigned CW = $clog2(OutDepth) + 1;

  // front side: classify and queue
  logic   q_empty;
  item_t  q_item;
  logic   issue;

  // back side: divider, series, result queue
  logic   div_vld, poly_vld;
  zitem_t div_item;
  res_t   poly_res, out_res;

  // slots reserved in the result queue: items in flight plus items waiting
  logic [CW-1:0] cred_r, cred_nxt;
  logic          pop_ok;

  assign pop_ok = out_pop && !out_empty;
  // an item enters the back only when its result is sure to have a slot
  assign issue  = !q_empty && ((cred_r != CW'(OutDepth)) || pop_ok);

  always_comb begin
    cred_nxt = cred_r + CW'(issue) - CW'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_nxt;
    end
  end

  nlf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_x_bits (in_x_bits),
    .deq       (issue),
    .q_empty   (q_empty),
    .q_item    (q_item)
  );

  nlf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (issue),
    .in_item  (q_item),
    .out_vld  (div_vld),
    .out_item (div_item)
  );

  nlf_poly #(
    .FRAC_BITS (FRAC_BITS)
  ) u_poly (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (div_vld),
    .in_item (div_item),
    .out_vld (poly_vld),
    .out_res (poly_res)
  );

  nlf_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (poly_vld),
    .wr_res (poly_res),
    .rd     (pop_ok),
    .empty  (out_empty),
    .rd_res (out_res)
  );

  assign out_ln_value = signed'(out_res.ln);
  assign out_invalid  = out_res.inv;

endmodule

// ----- sv/nlf_front.sv -----
// ----------------------------------------------------------------------------
// nlf_front
// classifies input items and holds them in a short queue
// ----------------------------------------------------------------------------
module nlf_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  output logic          in_full,
  input  logic [31:0]   in_x_bits,
  input  logic          deq,
  output logic          q_empty,
  output nlf_pkg::item_t q_item
);
  import nlf_pkg::*;

  localparam int unsigned PW = $clog2(MidDepth);

  item_t          mem_r [MidDepth];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]    cnt_r, cnt_nxt;
  item_t          cls;
  logic           wr_en;
  logic [8:0]     e9;

  // invalid: sign set, all-ones exponent, or zero
  always_comb begin
    e9       = {1'b0, in_x_bits[30:23]} - ExpBias;
    cls.inv  = (in_x_bits >= ExpMask) || (in_x_bits[30:0] == 31'd0);
    cls.expo = e9[7:0];
    cls.frac = in_x_bits[22:0];
  end

  assign in_full = (cnt_r == (PW+1)'(MidDepth));
  assign q_empty = (cnt_r == '0);
  assign wr_en   = in_push && !in_full;
  assign q_item  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr_en ? wp_r + 1'b1 : wp_r;
    rp_nxt  = deq ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(wr_en) - (PW+1)'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= cls;
    end
  end

endmodule

// ----- sv/nlf_div.sv -----
// ----------------------------------------------------------------------------
// nlf_div
// pipelined restoring divider, z = f*2^30 / (2^24 + f)
// ----------------------------------------------------------------------------
module nlf_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  nlf_pkg::item_t  in_item,
  output logic            out_vld,
  output nlf_pkg::zitem_t out_item
);
  import nlf_pkg::*;

  logic              vld_r  [DivStages];
  logic [25:0]       rem_r  [DivStages];
  logic [29:0]       q_r    [DivStages];
  logic [22:0]       frac_r [DivStages];
  logic signed [7:0] expo_r [DivStages];
  logic              inv_r  [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic [25:0]       rem_in, rem_nxt, sh;
    logic [29:0]       q_in, q_nxt;
    logic [22:0]       frac_in;
    logic signed [7:0] expo_in;
    logic              inv_in, vld_in;
    logic [25:0]       dv;

    if (s == 0) begin : g_first
      // f*2 is already below the divisor, so the top quotient bits are zero
      assign rem_in  = {2'b00, in_item.frac, 1'b0};
      assign q_in    = '0;
      assign frac_in = in_item.frac;
      assign expo_in = in_item.expo;
      assign inv_in  = in_item.inv;
      assign vld_in  = in_vld;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign q_in    = q_r[s-1];
      assign frac_in = frac_r[s-1];
      assign expo_in = expo_r[s-1];
      assign inv_in  = inv_r[s-1];
      assign vld_in  = vld_r[s-1];
    end

    assign dv = {2'b01, 1'b0, frac_in};

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      sh      = '0;
      for (int j = 0; j < 2; j++) begin
        sh = {rem_nxt[24:0], 1'b0};
        if (sh >= dv) begin
          rem_nxt = sh - dv;
          q_nxt   = {q_nxt[28:0], 1'b1};
        end else begin
          rem_nxt = sh;
          q_nxt   = {q_nxt[28:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s]  <= rem_nxt;
      q_r[s]    <= q_nxt;
      frac_r[s] <= frac_in;
      expo_r[s] <= expo_in;
      inv_r[s]  <= inv_in;
    end
  end

  // one extra quotient bit was produced, drop it
  assign out_vld       = vld_r[DivStages-1];
  assign out_item.inv  = inv_r[DivStages-1];
  assign out_item.expo = expo_r[DivStages-1];
  assign out_item.z    = q_r[DivStages-1][29:1];

endmodule

// ----- sv/nlf_poly.sv -----
// ----------------------------------------------------------------------------
// nlf_poly
// series evaluation, exponent term and rounding, one multiply per series step
// ----------------------------------------------------------------------------
module nlf_poly #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  nlf_pkg::zitem_t in_item,
  output logic            out_vld,
  output nlf_pkg::res_t   out_res
);
  import nlf_pkg::*;

  localparam int unsigned Sh = 30 - FRAC_BITS;
  localparam logic signed [39:0] Half = 40'sd1 <<< (Sh - 1);

  logic [6:0]        vld_r;
  logic [28:0]       z_r   [5];
  logic signed [7:0] expo_r[5];
  logic              inv_r [6];
  logic [27:0]       z2_r  [4];
  logic [30:0]       p_r   [4];
  logic [30:0]       lnm_r;
  logic signed [38:0] eln_r;
  res_t              res_r;

  logic [57:0]        zz;
  logic [58:0]        hm [4];
  logic [30:0]        cf [4];
  logic [30:0]        pin [4];
  logic [59:0]        zp;
  logic signed [38:0] el;
  logic signed [39:0] sum, rsum;

  assign cf[0] = C7Q30;
  assign cf[1] = C5Q30;
  assign cf[2] = C3Q30;
  assign cf[3] = OneQ30;

  // innermost step starts from c9
  assign pin[0] = C9Q30;
  assign pin[1] = p_r[0];
  assign pin[2] = p_r[1];
  assign pin[3] = p_r[2];

  always_comb begin
    zz = 58'(in_item.z) * 58'(in_item.z);
    for (int k = 0; k < 4; k++) begin
      hm[k] = 59'(z2_r[k]) * 59'(pin[k]);
    end
    zp   = 60'(z_r[4]) * 60'(p_r[3]);
    el   = 39'(expo_r[4]) * 39'(signed'({1'b0, Ln2Q30}));
    sum  = 40'(eln_r) + 40'(signed'({1'b0, lnm_r}));
    rsum = (sum + Half) >>> Sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    z_r[0]    <= in_item.z;
    expo_r[0] <= in_item.expo;
    inv_r[0]  <= in_item.inv;
    z2_r[0]   <= zz[57:30];
    for (int k = 1; k < 5; k++) begin
      z_r[k]    <= z_r[k-1];
      expo_r[k] <= expo_r[k-1];
    end
    for (int k = 1; k < 6; k++) begin
      inv_r[k]  <= inv_r[k-1];
    end
    for (int k = 1; k < 4; k++) begin
      z2_r[k] <= z2_r[k-1];
    end
    for (int k = 0; k < 4; k++) begin
      p_r[k] <= cf[k] + 31'(hm[k][58:30]);
    end
    lnm_r     <= zp[59:29];
    eln_r     <= el;
    res_r.inv <= inv_r[5];
    res_r.ln  <= inv_r[5] ? 32'd0 : rsum[31:0];
  end

  assign out_vld = vld_r[6];
  assign out_res = res_r;

endmodule

// ----- sv/nlf_outq.sv -----
// ----------------------------------------------------------------------------
// nlf_outq
// result queue in front of the output port
// ----------------------------------------------------------------------------
module nlf_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr,
  input  nlf_pkg::res_t wr_res,
  input  logic          rd,
  output logic          empty,
  output nlf_pkg::res_t rd_res
);
  import nlf_pkg::*;

  localparam int unsigned PW = $clog2(OutDepth);

  res_t          mem_r [OutDepth];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;

  assign empty  = (cnt_r == '0);
  assign rd_res = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(wr) - (PW+1)'(rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wp_r] <= wr_res;
    end
  end

endmodule

// ----- sv/nlf_checker.sv -----
// ----------------------------------------------------------------------------
// nlf_checker
// port-level checks for the natural log block
// ----------------------------------------------------------------------------
module nlf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic [31:0]        in_x_bits,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_ln_value,
  input logic               out_invalid
);

  // reset leaves nothing to deliver
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // reset leaves room for input
  a_rst_room: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  // an accepted item carries a known pattern
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> !$isunknown(in_x_bits))
    else $error("accepted item with unknown bits");

  // an invalid item carries a zero value
  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_invalid) |-> (out_ln_value == 32'sd0))
    else $error("invalid result with nonzero value");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_ln_value) && $stable(out_invalid)))
    else $error("waiting result changed");

endmodule

bind natural_log_float_to_fixed nlf_checker u_nlf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_push      (in_push),
  .in_full      (in_full),
  .in_x_bits    (in_x_bits),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_ln_value (out_ln_value),
  .out_invalid  (out_invalid)
);

// ----- tb/natural_log_float_to_fixed_checker.sv -----
// ----------------------------------------------------------------------------
// natural_log_float_to_fixed_checker
// watches both queue ports, predicts each log result and compares it
// ----------------------------------------------------------------------------
module natural_log_float_to_fixed_checker #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [31:0]        in_x_bits,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [31:0] out_ln_value,
  input  logic               out_invalid,
  output int                 fail_count,
  output int                 pending_logs,
  output int                 invalid_seen
);
  import nlf_pkg::*;

  typedef struct packed {
    logic        inv;
    logic [31:0] ln;
  } log_result_t;

  log_result_t expected_logs[$];

  function automatic log_result_t compute_log(logic [31:0] bits);
    log_result_t r;
    logic [63:0] f, z, z2, p, lnm, sum, half;
    int e;
    int unsigned sh;
    sh = 30 - FRAC_BITS;
    r.inv = 1'b0;
    r.ln  = '0;
    if (bits >= ExpMask || bits[30:0] == 31'd0) begin
      r.inv = 1'b1;
      return r;
    end
    e  = int'(bits[30:23]) - int'(ExpBias);
    f  = {41'd0, bits[22:0]};
    z  = (f << 30) / (64'h0100_0000 + f);
    z2 = (z * z) >> 30;
    p  = {33'd0, C9Q30};
    p  = {33'd0, C7Q30} + ((z2 * p) >> 30);
    p  = {33'd0, C5Q30} + ((z2 * p) >> 30);
    p  = {33'd0, C3Q30} + ((z2 * p) >> 30);
    p  = {33'd0, OneQ30} + ((z2 * p) >> 30);
    lnm = (z * p) >> 29;
    sum = 64'(longint'(e) * longint'({33'd0, Ln2Q30})) + lnm;
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    sum = 64'($signed(sum + half) >>> sh);
    r.ln = sum[31:0];
    return r;
  endfunction

  initial pending_logs = 0;

  always @(posedge clk) begin
    log_result_t want;
    if (!rst_n) begin
      fail_count   <= 0;
      invalid_seen <= 0;
      expected_logs.delete();
    end else begin
      if (in_push && !in_full) expected_logs.push_back(compute_log(in_x_bits));
      if (out_pop && !out_empty) begin
        if (expected_logs.size() == 0) begin
          if (fail_count < 10) $display("unexpected result ln=%h inv=%b", out_ln_value,
                                        out_invalid);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_logs.pop_front();
          if (out_invalid) invalid_seen <= invalid_seen + 1;
          if (want.ln !== out_ln_value || want.inv !== out_invalid) begin
            if (fail_count < 10)
              $display("mismatch: want ln=%h inv=%b, got ln=%h inv=%b",
                       want.ln, want.inv, out_ln_value, out_invalid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_logs = expected_logs.size();
  end
endmodule

// ----- tb/natural_log_float_to_fixed_test.sv -----
// ----------------------------------------------------------------------------
// natural_log_float_to_fixed_test
// drives float patterns in bursts, stalls the result side, checks every log
// ----------------------------------------------------------------------------
module natural_log_float_to_fixed_test;
  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [31:0]        in_x_bits;
  logic               out_empty;
  logic               out_pop;
  logic signed [31:0] out_ln_value;
  logic               out_invalid;
  int                 fail_count;
  int                 pending_logs;
  int                 invalid_seen;
  int                 items_sent;
  int                 idle_cycles;
  bit                 stim_done;
  bit                 hold_off;

  natural_log_float_to_fixed dut (.*);

  natural_log_float_to_fixed_checker chk (.*);

  // directed corner patterns
  logic [31:0] corner_items[22] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'h7F80_0001, 32'hBF80_0000, 32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000,
    32'h3F80_0000, 32'h3FFF_FFFF, 32'h4000_0000, 32'h7F7F_FFFF, 32'h402D_F854,
    32'h3F7F_FFFF, 32'h3F80_0001, 32'h3FC0_0000, 32'hFFFF_FFFF, 32'h5555_5555,
    32'h2AAA_AAAA, 32'h7FFF_FFFF};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random pattern: mostly valid positives, some specials and raw noise
  function automatic logic [31:0] random_item();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0:       v = v;                                     // any pattern
      1:       v = {1'b0, 8'd0, v[22:0]};                 // subnormal
      2:       v = {1'b0, 8'hFF, v[22:0]};                // inf or nan
      3:       v = {1'b1, v[30:0]};                       // negative
      4:       v = {1'b0, 8'h7F - 8'(v[24:23]), v[22:0]}; // near one
      default: v = {1'b0, v[30:0]};
    endcase
    return v;
  endfunction

  // sender: bursts with gaps, changes at falling edge, holds an item until taken
  initial begin
    int burst;
    logic [31:0] cur_x;
    rst_n = 1'b0; in_push = 1'b0; in_x_bits = '0; stim_done = 1'b0; items_sent = 0;
    cur_x = corner_items[0];
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    while (items_sent < 1522) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && items_sent < 1522) begin
        in_push   <= 1'b1;
        in_x_bits <= cur_x;
        @(posedge clk);
        if (!in_full) begin
          items_sent++;
          burst--;
          cur_x = (items_sent < 22) ? corner_items[items_sent] : random_item();
        end
        @(negedge clk);
      end
      if ($urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    in_push <= 1'b0;
    stim_done = 1'b1;
  end

  // long hold-off on the result side so the input queue fills
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= 200);
    @(negedge clk) hold_off = 1'b1;
    repeat (150) @(negedge clk);
    hold_off = 1'b0;
  end

  // receiver: own stall pattern, with calm stretches
  initial begin
    out_pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_pop <= 1'b0;
      else if ((items_sent / 256) % 2 == 1) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(0, 2) != 0);
    end
  end

  // watchdog on cycles with nothing accepted
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("natural_log_float_to_fixed_test NOT OK");
      $finish;
    end
  end

  // end of run: drain, then settle for the pipeline latency
  initial begin
    wait (stim_done);
    wait (pending_logs == 0);
    repeat (60) @(posedge clk);
    $display("sent %0d float patterns incl. corners, %0d flagged invalid, with stalls",
             items_sent, invalid_seen);
    if (fail_count == 0 && pending_logs == 0) begin
      $display("natural_log_float_to_fixed_test OK");
    end else begin
      $display("natural_log_float_to_fixed_test NOT OK");
    end
    $finish;
  end
endmodule
